>>> design/media_position_clock_assert.svh
// Assertion macros used by the checker of the position clock
`ifndef MEDIA_POSITION_CLOCK_ASSERT_SVH
`define MEDIA_POSITION_CLOCK_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("position clock check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("position clock check failed");

`endif

>>> design/mpc_pkg.sv
// Types, constants and helpers of the playback position clock
package mpc_pkg;

  localparam int ACT_W   = 3;
  localparam int TIME_W  = 48;
  localparam int MS_W    = 40;
  localparam int DELAY_W = 20;
  localparam int SCALE_W = 16;
  localparam int EPOCH_W = 16;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = MS_W + FRAC_W;
  localparam int PROD_W  = TIME_W + SCALE_W;
  localparam int DPROD_W = DELAY_W + SCALE_W;
  localparam int DMS_W   = DPROD_W - 12;
  localparam int MODE_W  = 2;

  localparam int DIV_CYCLES = PROD_W / 8;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [ACT_W-1:0] ACT_APPLY   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PUBLISH = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SYNC    = 3'd5;

  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

  localparam logic [SCALE_W-1:0] RATE_ONE   = 16'd4096;
  localparam logic [SCALE_W-1:0] DSCALE_MIN = 16'd41;
  localparam logic [SCALE_W-1:0] RATE_MIN   = 16'd205;
  localparam logic [SCALE_W-1:0] SCALE_MAX  = 16'd32768;

  localparam logic [7:0]       US_DIVISOR = 8'd125;
  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
  localparam logic [MS_W-1:0]  REP_MAX    = {MS_W{1'b1}};

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic pred;
    logic upd;
    logic rep;
  } mpc_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } mpc_stat_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(logic [SCALE_W-1:0] v,
                                                     logic [SCALE_W-1:0] lo);
    logic [SCALE_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > SCALE_MAX) r = SCALE_MAX;
    return r;
  endfunction

endpackage

>>> design/mpc_if.sv
// Valid/ready channels of the position clock
interface mpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpc_pkg::ACT_W-1:0]    action;
  logic [mpc_pkg::TIME_W-1:0]   now_time;
  logic [mpc_pkg::MS_W-1:0]     source_position;
  logic [mpc_pkg::DELAY_W-1:0]  output_delay;
  logic [mpc_pkg::SCALE_W-1:0]  delay_scale;
  logic [mpc_pkg::EPOCH_W-1:0]  epoch_in;
  logic                         discontinuity;
  logic                         emit_now;
  logic [mpc_pkg::MS_W-1:0]     fallback_position;

  modport source (output valid, action, now_time, source_position, output_delay,
                  delay_scale, epoch_in, discontinuity, emit_now, fallback_position,
                  input ready);
  modport sink (input valid, action, now_time, source_position, output_delay,
                delay_scale, epoch_in, discontinuity, emit_now, fallback_position,
                output ready);
endinterface

interface mpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpc_pkg::MS_W-1:0]     reported_position;
  logic                         position_changed;
  logic [mpc_pkg::EPOCH_W-1:0]  current_epoch;
  logic                         sync_request;

  modport source (output valid, reported_position, position_changed, current_epoch,
                  sync_request, input ready);
  modport sink (input valid, reported_position, position_changed, current_epoch,
                sync_request, output ready);
endinterface

>>> design/mpc_ctrl.sv
// Sequencer of the position clock: load, multiply, divide, predict, update, report
module mpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpc_pkg::mpc_stat_t  stat_i,
  output mpc_pkg::mpc_cmd_t   cmd_o,
  output logic                in_ready_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PRED = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_REP  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [mpc_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == mpc_pkg::DIV_CNT_W'(mpc_pkg::DIV_CYCLES - 1)) state_d = S_PRED;
      end
      S_PRED: begin
        cmd_o.pred = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_REP;
      end
      S_REP: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.rep = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> design/mpc_dp.sv
// Datapath of the position clock: clock state, multiplies, divide by 125, report
module mpc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpc_pkg::mpc_cmd_t             cmd_i,
  output mpc_pkg::mpc_stat_t            stat_o,
  input  logic                          in_valid_i,
  input  logic [mpc_pkg::ACT_W-1:0]     action_i,
  input  logic [mpc_pkg::TIME_W-1:0]    now_time_i,
  input  logic [mpc_pkg::MS_W-1:0]      source_position_i,
  input  logic [mpc_pkg::DELAY_W-1:0]   output_delay_i,
  input  logic [mpc_pkg::SCALE_W-1:0]   delay_scale_i,
  input  logic [mpc_pkg::EPOCH_W-1:0]   epoch_in_i,
  input  logic                          discontinuity_i,
  input  logic                          emit_now_i,
  input  logic [mpc_pkg::MS_W-1:0]      fallback_position_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mpc_pkg::MS_W-1:0]      reported_position_o,
  output logic                          position_changed_o,
  output logic [mpc_pkg::EPOCH_W-1:0]   current_epoch_o,
  output logic                          sync_request_o
);

  // clock state
  logic [mpc_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [mpc_pkg::EPOCH_W-1:0]  epoch_q, epoch_d;
  logic                         av_q, av_d;
  logic [mpc_pkg::POS_W-1:0]    apos_q, apos_d;
  logic [mpc_pkg::TIME_W-1:0]   ats_q, ats_d;
  logic [mpc_pkg::POS_W-1:0]    lout_q, lout_d;
  logic [mpc_pkg::SCALE_W-1:0]  rate_q, rate_d;
  logic [mpc_pkg::MS_W-1:0]     lrep_q, lrep_d;

  // latched word
  logic [mpc_pkg::ACT_W-1:0]    act_q;
  logic [mpc_pkg::TIME_W-1:0]   now_q;
  logic [mpc_pkg::TIME_W-1:0]   elapsed_q;
  logic [mpc_pkg::MS_W-1:0]     src_q;
  logic [mpc_pkg::DELAY_W-1:0]  delay_q;
  logic [mpc_pkg::SCALE_W-1:0]  ds_q;
  logic [mpc_pkg::SCALE_W-1:0]  reff_q;
  logic [mpc_pkg::EPOCH_W-1:0]  ep_in_q;
  logic                         disc_q;
  logic                         emit_q;
  logic [mpc_pkg::MS_W-1:0]     fb_q;

  // working registers
  logic [mpc_pkg::DPROD_W-1:0]  dprod_q;
  logic [mpc_pkg::PROD_W-1:0]   div_q;
  logic [mpc_pkg::PROD_W-1:0]   quo_q;
  logic [6:0]                   rem_q;
  logic [mpc_pkg::POS_W-1:0]    pred_q;
  logic [mpc_pkg::POS_W-1:0]    pres_q;
  logic [mpc_pkg::POS_W-1:0]    rsrc_q;
  logic                         rep_en_q;
  logic                         sync_q;

  // output register
  logic                         out_valid_q;
  logic [mpc_pkg::MS_W-1:0]     out_pos_q;
  logic                         out_chg_q;
  logic [mpc_pkg::EPOCH_W-1:0]  out_ep_q;
  logic                         out_sync_q;

  // combinational helpers
  logic [mpc_pkg::TIME_W-1:0]   elapsed_d;
  logic [mpc_pkg::PROD_W-1:0]   product;
  logic [mpc_pkg::DPROD_W-1:0]  dproduct;
  logic [7:0]                   qbyte;
  logic [6:0]                   rem_d;
  logic [mpc_pkg::POS_W:0]      ext_sum;
  logic [mpc_pkg::POS_W-1:0]    extrap;
  logic [mpc_pkg::POS_W-1:0]    pred_d;
  logic [mpc_pkg::DPROD_W-1:0]  dround;
  logic [mpc_pkg::MS_W-1:0]     dms;
  logic [mpc_pkg::POS_W-1:0]    pres_d;
  logic [mpc_pkg::POS_W-1:0]    pos_max2;
  logic [mpc_pkg::POS_W-1:0]    pos_max3;
  logic                         hard;
  logic [mpc_pkg::POS_W-1:0]    rsrc_d;
  logic                         rep_en_d;
  logic                         sync_d;
  logic [mpc_pkg::POS_W:0]      rsum;
  logic [mpc_pkg::MS_W-1:0]     ms;

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign elapsed_d = (now_time_i > ats_q) ? now_time_i - ats_q : '0;
  assign product   = mpc_pkg::PROD_W'(elapsed_q) * mpc_pkg::PROD_W'(reff_q);
  assign dproduct  = mpc_pkg::DPROD_W'(delay_q) * mpc_pkg::DPROD_W'(ds_q);

  // eight restoring steps of the divide by 125, top byte first
  always_comb begin
    logic [7:0] r;
    logic [6:0] rr;
    rr    = rem_q;
    qbyte = '0;
    for (int i = 0; i < 8; i++) begin
      r = {rr, div_q[mpc_pkg::PROD_W-1-i]};
      if (r >= mpc_pkg::US_DIVISOR) begin
        qbyte[7-i] = 1'b1;
        r          = r - mpc_pkg::US_DIVISOR;
      end
      rr = r[6:0];
    end
    rem_d = rr;
  end

  // prediction and presented position
  always_comb begin
    ext_sum = {1'b0, apos_q} + {1'b0, quo_q[mpc_pkg::POS_W-1:0]};
    if ((|quo_q[mpc_pkg::PROD_W-1:mpc_pkg::POS_W]) || ext_sum[mpc_pkg::POS_W])
      extrap = mpc_pkg::POS_MAX;
    else
      extrap = ext_sum[mpc_pkg::POS_W-1:0];
    if (!av_q) pred_d = '0;
    else if (mode_q == mpc_pkg::MODE_PLAYING) pred_d = extrap;
    else pred_d = apos_q;

    dround = dprod_q + mpc_pkg::DPROD_W'(2048);
    dms    = mpc_pkg::MS_W'(dround[mpc_pkg::DPROD_W-1:12]);
    if (src_q > dms) pres_d = {src_q - dms, {mpc_pkg::FRAC_W{1'b0}}};
    else pres_d = '0;
  end

  // state update
  always_comb begin
    mode_d   = mode_q;
    epoch_d  = epoch_q;
    av_d     = av_q;
    apos_d   = apos_q;
    ats_d    = ats_q;
    lout_d   = lout_q;
    rate_d   = rate_q;
    lrep_d   = lrep_q;
    rsrc_d   = pred_q;
    rep_en_d = 1'b0;
    sync_d   = 1'b0;
    hard     = disc_q || !av_q || (mode_q != mpc_pkg::MODE_PLAYING) || (ep_in_q != epoch_q);
    pos_max2 = (lout_q > pres_q) ? lout_q : pres_q;
    pos_max3 = (pred_q > pos_max2) ? pred_q : pos_max2;
    case (act_q)
      mpc_pkg::ACT_APPLY: begin
        rate_d = reff_q;
        av_d   = 1'b1;
        ats_d  = now_q;
        if (hard) begin
          epoch_d = ep_in_q;
          lout_d  = pres_q;
          apos_d  = pres_q;
          rsrc_d  = pres_q;
        end else begin
          lout_d = pos_max3;
          apos_d = pos_max3;
          rsrc_d = pos_max3;
        end
        rep_en_d = emit_q;
      end
      mpc_pkg::ACT_PLAY: begin
        apos_d = av_q ? pred_q : {fb_q, {mpc_pkg::FRAC_W{1'b0}}};
        lout_d = av_q ? pred_q : {fb_q, {mpc_pkg::FRAC_W{1'b0}}};
        av_d   = 1'b1;
        ats_d  = now_q;
        mode_d = mpc_pkg::MODE_PLAYING;
      end
      mpc_pkg::ACT_PAUSE: begin
        apos_d   = pred_q;
        lout_d   = pred_q;
        av_d     = 1'b1;
        ats_d    = now_q;
        mode_d   = mpc_pkg::MODE_PAUSED;
        rep_en_d = 1'b1;
      end
      mpc_pkg::ACT_STOP: begin
        mode_d  = mpc_pkg::MODE_STOPPED;
        epoch_d = '0;
        av_d    = 1'b0;
        apos_d  = '0;
        ats_d   = '0;
        lout_d  = '0;
        rate_d  = mpc_pkg::RATE_ONE;
        lrep_d  = '0;
      end
      mpc_pkg::ACT_PUBLISH: rep_en_d = 1'b1;
      mpc_pkg::ACT_SYNC:    sync_d = 1'b1;
      default: ;
    endcase
  end

  // rounded milliseconds
  always_comb begin
    rsum = {1'b0, rsrc_q} + (mpc_pkg::POS_W + 1)'(32768);
    if (rsum[mpc_pkg::POS_W]) ms = mpc_pkg::REP_MAX;
    else ms = rsum[mpc_pkg::POS_W-1:mpc_pkg::FRAC_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mpc_pkg::MODE_STOPPED;
      epoch_q     <= '0;
      av_q        <= 1'b0;
      apos_q      <= '0;
      ats_q       <= '0;
      lout_q      <= '0;
      rate_q      <= mpc_pkg::RATE_ONE;
      lrep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        mode_q  <= mode_d;
        epoch_q <= epoch_d;
        av_q    <= av_d;
        apos_q  <= apos_d;
        ats_q   <= ats_d;
        lout_q  <= lout_d;
        rate_q  <= rate_d;
        lrep_q  <= lrep_d;
      end else if (cmd_i.rep && rep_en_q) begin
        lrep_q <= ms;
      end
      if (cmd_i.rep) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      now_q     <= now_time_i;
      elapsed_q <= elapsed_d;
      src_q     <= source_position_i;
      delay_q   <= output_delay_i;
      ds_q      <= mpc_pkg::clamp_scale(delay_scale_i, mpc_pkg::DSCALE_MIN);
      // an apply predicts with its own rate
      reff_q    <= (action_i == mpc_pkg::ACT_APPLY) ?
                   mpc_pkg::clamp_scale(delay_scale_i, mpc_pkg::RATE_MIN) : rate_q;
      ep_in_q   <= epoch_in_i;
      disc_q    <= discontinuity_i;
      emit_q    <= emit_now_i;
      fb_q      <= fallback_position_i;
    end
    if (cmd_i.mul) begin
      dprod_q <= dproduct;
      div_q   <= {product[mpc_pkg::PROD_W-2:0], 1'b0};
      quo_q   <= '0;
      rem_q   <= '0;
    end
    if (cmd_i.div) begin
      div_q <= {div_q[mpc_pkg::PROD_W-9:0], 8'd0};
      quo_q <= {quo_q[mpc_pkg::PROD_W-9:0], qbyte};
      rem_q <= rem_d;
    end
    if (cmd_i.pred) begin
      pred_q <= pred_d;
      pres_q <= pres_d;
    end
    if (cmd_i.upd) begin
      rsrc_q   <= rsrc_d;
      rep_en_q <= rep_en_d;
      sync_q   <= sync_d;
    end
    if (cmd_i.rep) begin
      out_pos_q  <= rep_en_q ? ms : lrep_q;
      out_chg_q  <= rep_en_q && (ms != lrep_q);
      out_ep_q   <= epoch_q;
      out_sync_q <= sync_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign reported_position_o = out_pos_q;
  assign position_changed_o  = out_chg_q;
  assign current_epoch_o     = out_ep_q;
  assign sync_request_o      = out_sync_q;

endmodule

>>> design/media_position_clock.sv
// Top level of the playback position clock
//
//   channel   dir  modport  payload
//   in_ch_i   in   sink     action, now_time, positions, delay, scale, epoch, flags
//   out_ch_o  out  source   reported_position, position_changed, current_epoch, sync
//
// One word at a time: from acceptance to result a word passes through load, multiply,
// the divide by 125, predict, update and report.
// The divide by 125 works on the elapsed-time product a byte at a time.
// A new word is taken as soon as the previous result sits in the output register.
// A stalled output holds the sequencer in its report step.
// Reset is asynchronous, active low, and returns the clock to stopped, rate 1.0.
module media_position_clock (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpc_in_if.sink     in_ch_i,
  mpc_out_if.source  out_ch_o
);

  mpc_pkg::mpc_cmd_t   cmd;
  mpc_pkg::mpc_stat_t  stat;
  logic                in_ready;

  mpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  mpc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .in_valid_i          (in_ch_i.valid),
    .action_i            (in_ch_i.action),
    .now_time_i          (in_ch_i.now_time),
    .source_position_i   (in_ch_i.source_position),
    .output_delay_i      (in_ch_i.output_delay),
    .delay_scale_i       (in_ch_i.delay_scale),
    .epoch_in_i          (in_ch_i.epoch_in),
    .discontinuity_i     (in_ch_i.discontinuity),
    .emit_now_i          (in_ch_i.emit_now),
    .fallback_position_i (in_ch_i.fallback_position),
    .out_ready_i         (out_ch_o.ready),
    .out_valid_o         (out_ch_o.valid),
    .reported_position_o (out_ch_o.reported_position),
    .position_changed_o  (out_ch_o.position_changed),
    .current_epoch_o     (out_ch_o.current_epoch),
    .sync_request_o      (out_ch_o.sync_request)
  );

  assign in_ch_i.ready = in_ready;

endmodule

>>> design/mpc_checker.sv
// Port-level checks of the position clock and their binding
`include "media_position_clock_assert.svh"

module mpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mpc_pkg::MS_W-1:0]     reported_position_i,
  input logic                         position_changed_i,
  input logic                         sync_request_i
);

  // a sync tick never carries a report
  `MPC_ASSERT_IMP(a_sync_no_change, out_valid_i && sync_request_i, !position_changed_i)
  // one word in flight: after acceptance the input closes
  `MPC_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i)
  // a result that waits stays offered
  `MPC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // and its position does not move
  `MPC_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(reported_position_i))

endmodule

bind media_position_clock mpc_checker u_mpc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_ch_i.valid),
  .in_ready_i          (in_ch_i.ready),
  .out_valid_i         (out_ch_o.valid),
  .out_ready_i         (out_ch_o.ready),
  .reported_position_i (out_ch_o.reported_position),
  .position_changed_i  (out_ch_o.position_changed),
  .sync_request_i      (out_ch_o.sync_request)
);

>>> tb/media_position_clock_test.sv
// Self-checking testbench of the playback position clock
module media_position_clock_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpc_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 1830;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [TIME_W-1:0]  now_us;
    logic [MS_W-1:0]    src_ms;
    logic [DELAY_W-1:0] delay_ms;
    logic [SCALE_W-1:0] scale;
    logic [EPOCH_W-1:0] gen;
    logic               disc;
    logic               emit;
    logic [MS_W-1:0]    fallback_ms;
  } cmd_word_t;

  typedef struct packed {
    logic [MS_W-1:0]    pos_ms;
    logic               changed;
    logic [EPOCH_W-1:0] gen;
    logic               sync;
  } report_t;

  logic clk_i;
  logic rst_ni;

  mpc_in_if  in_ch ();
  mpc_out_if out_ch ();

  media_position_clock i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // clock model state
  logic [MODE_W-1:0]  mode_q;
  logic [EPOCH_W-1:0] gen_q;
  logic               anchored;
  logic [POS_W-1:0]   anc_pos;
  logic [TIME_W-1:0]  anc_us;
  logic [POS_W-1:0]   out_floor;
  logic [SCALE_W-1:0] rate_q;
  logic [MS_W-1:0]    shown_ms;

  report_t due_q[$];

  logic [TIME_W-1:0] clock_us;
  int    burst_left;
  int    errors;
  int    words_sent;
  int    reports_seen;
  int    changed_seen;
  int    syncs_seen;
  int    cycles;
  bit    hold_req;
  int    hold_left;
  logic [11:0] rx_cycle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [SCALE_W-1:0] bound_scale(logic [SCALE_W-1:0] v,
                                                     logic [SCALE_W-1:0] lo);
    if (v < lo) return lo;
    if (v > SCALE_MAX) return SCALE_MAX;
    return v;
  endfunction

  function automatic void clear_clock();
    mode_q    = MODE_STOPPED;
    gen_q     = '0;
    anchored  = 1'b0;
    anc_pos   = '0;
    anc_us    = '0;
    out_floor = '0;
    rate_q    = RATE_ONE;
    shown_ms  = '0;
  endfunction

  function automatic void re_anchor(logic [POS_W-1:0] p, logic [TIME_W-1:0] t);
    anchored = 1'b1;
    anc_pos  = p;
    anc_us   = t;
  endfunction

  // anchor advanced by elapsed us * rate; frozen unless playing
  function automatic logic [POS_W-1:0] extrapolate(logic [TIME_W-1:0] t);
    logic [63:0] dt, rate64, off, sum;
    if (!anchored) return '0;
    if (mode_q != MODE_PLAYING) return anc_pos;
    dt     = (t > anc_us) ? {16'd0, t - anc_us} : 64'd0;
    rate64 = {48'd0, rate_q};
    off    = (dt * rate64 * 64'd2) / 64'd125;
    sum    = {8'd0, anc_pos} + off;
    if (sum > {8'd0, POS_MAX}) return POS_MAX;
    return sum[POS_W-1:0];
  endfunction

  function automatic logic publish_ms(logic [POS_W-1:0] p);
    logic [63:0] ms;
    logic        diff;
    ms = ({8'd0, p} + 64'h8000) >> 16;
    if (ms > {24'd0, REP_MAX}) ms = {24'd0, REP_MAX};
    diff     = (ms[MS_W-1:0] != shown_ms);
    shown_ms = ms[MS_W-1:0];
    return diff;
  endfunction

  function automatic report_t step_clock(cmd_word_t w);
    report_t          r;
    logic [63:0]      dsc, lag, src64, pres64;
    logic [POS_W-1:0] presented, pos, pred;
    r.changed = 1'b0;
    r.sync    = 1'b0;
    case (w.action)
      ACT_APPLY: begin
        dsc       = {48'd0, bound_scale(w.scale, DSCALE_MIN)};
        lag       = ({44'd0, w.delay_ms} * dsc + 64'd2048) >> 12;
        src64     = {24'd0, w.src_ms};
        pres64    = (src64 > lag) ? ((src64 - lag) << 16) : 64'd0;
        presented = pres64[POS_W-1:0];
        rate_q    = bound_scale(w.scale, RATE_MIN);
        if (w.disc || !anchored || mode_q != MODE_PLAYING || w.gen != gen_q) begin
          gen_q     = w.gen;
          out_floor = presented;
          re_anchor(presented, w.now_us);
        end else begin
          pred = extrapolate(w.now_us);
          pos  = presented;
          if (out_floor > pos) pos = out_floor;
          if (pred > pos) pos = pred;
          out_floor = pos;
          re_anchor(pos, w.now_us);
        end
        if (w.emit) r.changed = publish_ms(extrapolate(w.now_us));
      end
      ACT_PLAY: begin
        pos = anchored ? extrapolate(w.now_us) : {w.fallback_ms, 16'd0};
        re_anchor(pos, w.now_us);
        out_floor = pos;
        mode_q    = MODE_PLAYING;
      end
      ACT_PAUSE: begin
        pos = extrapolate(w.now_us);
        re_anchor(pos, w.now_us);
        out_floor = pos;
        mode_q    = MODE_PAUSED;
        r.changed = publish_ms(pos);
      end
      ACT_STOP:    clear_clock();
      ACT_PUBLISH: r.changed = publish_ms(extrapolate(w.now_us));
      ACT_SYNC:    r.sync = 1'b1;
      default: ;
    endcase
    r.pos_ms = shown_ms;
    r.gen    = gen_q;
    return r;
  endfunction

  // ------------------------------------------------------------- drivers

  task automatic send_word(cmd_word_t w);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      // long bursts now and then give stretches with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_ch.action            <= w.action;
    in_ch.now_time          <= w.now_us;
    in_ch.source_position   <= w.src_ms;
    in_ch.output_delay      <= w.delay_ms;
    in_ch.delay_scale       <= w.scale;
    in_ch.epoch_in          <= w.gen;
    in_ch.discontinuity     <= w.disc;
    in_ch.emit_now          <= w.emit;
    in_ch.fallback_position <= w.fallback_ms;
    in_ch.valid             <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    due_q.push_back(step_clock(w));
    words_sent++;
    burst_left--;
  endtask

  task automatic settle_input();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: slow-changing stall pattern plus one long hold-off on request
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 12'd1;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_cycle[11:10])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= (rx_cycle[3:0] > 4'd9);
      endcase
    end
  end

  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.pos_ms  = out_ch.reported_position;
      got.changed = out_ch.position_changed;
      got.gen     = out_ch.current_epoch;
      got.sync    = out_ch.sync_request;
      reports_seen++;
      if (got.changed === 1'b1) changed_seen++;
      if (got.sync === 1'b1) syncs_seen++;
      if (due_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = due_q.pop_front();
        if (got.pos_ms !== want.pos_ms) begin
          $error("reported_position: expected %0d, got %0d", want.pos_ms, got.pos_ms);
          errors++;
        end
        if (got.changed !== want.changed) begin
          $error("position_changed: expected %0d, got %0d", want.changed, got.changed);
          errors++;
        end
        if (got.gen !== want.gen) begin
          $error("current_epoch: expected %0d, got %0d", want.gen, got.gen);
          errors++;
        end
        if (got.sync !== want.sync) begin
          $error("sync_request: expected %0d, got %0d", want.sync, got.sync);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------ stimulus

  function automatic logic [MS_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[MS_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  function automatic cmd_word_t blank_word(logic [ACT_W-1:0] a, logic [TIME_W-1:0] t);
    cmd_word_t w;
    w        = '0;
    w.action = a;
    w.now_us = t;
    return w;
  endfunction

  // mostly forward steps of up to 40 ms, sometimes back, sometimes anywhere
  function automatic logic [TIME_W-1:0] next_us();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) clock_us = rand48();
    else if (r < 5) clock_us = clock_us - $urandom_range(0, 50000);
    else clock_us = clock_us + $urandom_range(0, 40000);
    return clock_us;
  endfunction

  function automatic cmd_word_t noise_word();
    cmd_word_t w;
    w.action      = $urandom_range(0, 7);
    w.now_us      = $urandom_range(0, 1) ? rand48() : next_us();
    w.src_ms      = rand40();
    w.delay_ms    = $urandom();
    w.scale       = $urandom();
    w.gen         = $urandom();
    w.disc        = $urandom_range(0, 1);
    w.emit        = $urandom_range(0, 1);
    w.fallback_ms = rand40();
    return w;
  endfunction

  // source position near where the clock already is, so the monotonic path runs
  function automatic cmd_word_t apply_word();
    cmd_word_t   w;
    logic [63:0] ahead, lag;
    w = blank_word(ACT_APPLY, next_us());
    if ($urandom_range(0, 9) == 0) begin
      w.delay_ms = $urandom();
      w.scale    = $urandom();
    end else begin
      w.delay_ms = $urandom_range(0, 400);
      w.scale    = $urandom_range(2048, 8192);
    end
    if ($urandom_range(0, 9) == 0) begin
      w.src_ms = rand40();
    end else begin
      ahead = {8'd0, extrapolate(w.now_us)} >> 16;
      lag   = ({44'd0, w.delay_ms} * {48'd0, w.scale}) >> 12;
      ahead = ahead + lag + $urandom_range(0, 80);
      ahead = (ahead > 64'd40) ? ahead - 64'd40 : 64'd0;
      w.src_ms = ahead[MS_W-1:0];
    end
    w.gen  = ($urandom_range(0, 19) == 0) ? gen_q + 16'd1 : gen_q;
    w.disc = ($urandom_range(0, 19) == 0);
    w.emit = $urandom_range(0, 1);
    return w;
  endfunction

  task automatic run_session();
    cmd_word_t w;
    int        steps, pick;
    if ($urandom_range(0, 3) == 0) send_word(blank_word(ACT_STOP, next_us()));
    w = blank_word(ACT_PLAY, next_us());
    w.fallback_ms = ($urandom_range(0, 9) == 0) ? rand40() : $urandom_range(0, 600000);
    send_word(w);
    steps = $urandom_range(3, 16);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_word(apply_word());
      end else if (pick < 75) begin
        send_word(blank_word(ACT_PUBLISH, next_us()));
      end else if (pick < 85) begin
        send_word(blank_word(ACT_PAUSE, next_us()));
        if ($urandom_range(0, 1)) send_word(apply_word());
        if ($urandom_range(0, 1)) send_word(blank_word(ACT_PUBLISH, next_us()));
        send_word(blank_word(ACT_PLAY, next_us()));
      end else if (pick < 92) begin
        send_word(blank_word(ACT_SYNC, next_us()));
      end else begin
        send_word(noise_word());
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_after_reset();
    cmd_word_t w;
    send_word(blank_word(ACT_SYNC, '0));
    w = noise_word();
    w.action = 3'd6;
    send_word(w);
    w = noise_word();
    w.action = 3'd7;
    send_word(w);
    send_word(blank_word(ACT_PUBLISH, 48'd100));
    send_word(blank_word(ACT_PAUSE, 48'd200));
  endtask

  task automatic test_fallback_saturation();
    cmd_word_t w;
    send_word(blank_word(ACT_STOP, 48'd0));
    w = blank_word(ACT_PLAY, 48'd1000);
    w.fallback_ms = REP_MAX;
    send_word(w);
    send_word(blank_word(ACT_PUBLISH, 48'd1000));
    send_word(blank_word(ACT_PUBLISH, 48'd2001000));
    send_word(blank_word(ACT_PAUSE, {TIME_W{1'b1}}));
    send_word(blank_word(ACT_STOP, {TIME_W{1'b1}}));
  endtask

  task automatic test_apply_scale_limits();
    cmd_word_t w;
    send_word(blank_word(ACT_PLAY, 48'd0));
    // delay larger than the source: presented position floors at zero
    w = blank_word(ACT_APPLY, 48'd1000);
    w.delay_ms = {DELAY_W{1'b1}};
    w.scale    = '0;
    w.emit     = 1'b1;
    send_word(w);
    w = blank_word(ACT_APPLY, 48'd2000);
    w.src_ms   = REP_MAX;
    w.delay_ms = {DELAY_W{1'b1}};
    w.scale    = {SCALE_W{1'b1}};
    w.gen      = {EPOCH_W{1'b1}};
    w.disc     = 1'b1;
    w.emit     = 1'b1;
    send_word(w);
    w = blank_word(ACT_APPLY, 48'd5000);
    w.src_ms = 40'd123456;
    w.scale  = SCALE_MAX;
    w.gen    = {EPOCH_W{1'b1}};
    w.emit   = 1'b1;
    send_word(w);
    w = blank_word(ACT_APPLY, 48'd9000);
    w.src_ms   = 40'd700000;
    w.delay_ms = 20'd250;
    w.scale    = 16'd204;
    w.gen      = {EPOCH_W{1'b1}};
    w.emit     = 1'b1;
    send_word(w);
  endtask

  task automatic test_time_before_anchor();
    cmd_word_t w;
    send_word(blank_word(ACT_STOP, 48'd0));
    w = blank_word(ACT_PLAY, 48'd500000);
    w.fallback_ms = 40'd1000;
    send_word(w);
    w = blank_word(ACT_APPLY, 48'd400000);
    w.src_ms = 40'd900;
    w.scale  = RATE_ONE;
    w.emit   = 1'b1;
    send_word(w);
    send_word(blank_word(ACT_PUBLISH, 48'd100));
  endtask

  task automatic test_monotonic_hold();
    cmd_word_t w;
    send_word(blank_word(ACT_STOP, 48'd0));
    w = blank_word(ACT_PLAY, 48'd0);
    w.fallback_ms = 40'd5000;
    send_word(w);
    // source behind the prediction: the prediction wins
    w = blank_word(ACT_APPLY, 48'd100000);
    w.src_ms = 40'd4000;
    w.scale  = RATE_ONE;
    w.emit   = 1'b1;
    send_word(w);
    // source ahead: jump forward
    w = blank_word(ACT_APPLY, 48'd200000);
    w.src_ms = 40'd9000;
    w.scale  = RATE_ONE;
    send_word(w);
    send_word(blank_word(ACT_PUBLISH, 48'd300000));
    send_word(blank_word(ACT_PAUSE, 48'd350000));
    send_word(blank_word(ACT_PUBLISH, 48'd900000));
  endtask

  task automatic test_output_hold_off();
    hold_req = 1'b1;
    repeat (2) run_session();
  endtask

  task automatic test_drain_pause();
    settle_input();
    repeat (3) run_session();
  endtask

  task automatic test_random_sessions(int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) send_word(noise_word());
      else run_session();
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.action            = '0;
    in_ch.now_time          = '0;
    in_ch.source_position   = '0;
    in_ch.output_delay      = '0;
    in_ch.delay_scale       = '0;
    in_ch.epoch_in          = '0;
    in_ch.discontinuity     = 1'b0;
    in_ch.emit_now          = 1'b0;
    in_ch.fallback_position = '0;
    out_ch.ready            = 1'b0;
    rx_cycle                = '0;
    clock_us                = '0;
    burst_left              = 0;
    hold_left               = 0;
    hold_req                = 1'b0;
    clear_clock();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_fallback_saturation();
    test_apply_scale_limits();
    test_time_before_anchor();
    test_monotonic_hold();
    test_random_sessions(RANDOM_WORDS / 2);
    test_output_hold_off();
    test_drain_pause();
    test_random_sessions(RANDOM_WORDS / 2);

    settle_input();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d words: %0d results, %0d changed reports, %0d sync ticks.",
             words_sent, reports_seen, changed_seen, syncs_seen);
    $display("Play/pause/stop/apply/publish sessions, noise words, bursts, stalls, hold-off.");
    if (errors == 0 && due_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
